@@ rtl/core/sexp_pkg.sv @@
// ----------------------------------------------------------------------------
// Stack expression evaluator package
// Shared widths, symbol codes, status codes and the structs that travel
// between the front end, the command queue, the stack engine and the ALU.
// ----------------------------------------------------------------------------
package sexp_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int STK_AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);

    localparam int DATA_W   = 32;
    localparam int SYM_W    = 8;
    localparam int STATUS_W = 3;
    localparam int DIGIT_W  = 4;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam int DIV_CW = $clog2(DATA_W);

    // ASCII codes of the accepted symbols.
    localparam logic [SYM_W-1:0] CH_0     = 8'h30;
    localparam logic [SYM_W-1:0] CH_9     = 8'h39;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [SYM_W-1:0] CH_CARET = 8'h5E;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADCHAR   = 3'd4;

    typedef enum logic [2:0] {
        OP_DIGIT = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_MUL   = 3'd3,
        OP_DIV   = 3'd4,
        OP_POW   = 3'd5,
        OP_BAD   = 3'd6
    } t_op;

    // One classified symbol as it sits in the command queue.
    typedef struct packed {
        t_op                op;
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } t_cmd;

    typedef struct packed {
        logic              start;
        t_op               op;
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
    } t_alu_req;

    typedef struct packed {
        logic              done;
        logic              err;
        logic [DATA_W-1:0] value;
    } t_alu_rsp;

endpackage

@@ rtl/core/sexp_if.sv @@
// ----------------------------------------------------------------------------
// Stack expression evaluator channel interfaces
// Valid/ready channels for incoming symbols and for outgoing results.
// ----------------------------------------------------------------------------
interface sexp_sym_if import sexp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             last_symbol;

    modport source (output valid, output symbol, output last_symbol, input ready);
    modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

interface sexp_res_if import sexp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [DATA_W-1:0]   value;
    logic        [STATUS_W-1:0] status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

@@ rtl/core/stack_expression_evaluator.sv @@
// ----------------------------------------------------------------------------
// Stack expression evaluator
// Evaluates postfix expressions, or prefix expressions fed right to left,
// one ASCII symbol per transfer, on a bounded stack of 32-bit words.
// ----------------------------------------------------------------------------
// Usage: symbols arrive on i_sym, one character per transfer, with
// last_symbol marking the final character of an expression. Only that final
// transfer produces a result on o_res: the top of stack as a signed value and
// a status code (ok, underflow, divide by zero, overflow, bad character).
// i_cfg_we with i_cfg_wdata selects the notation and is written while idle.
// A front end decodes each symbol into a four-entry command queue; the stack
// engine behind it executes one command at a time, so input transfers keep
// flowing until the queue fills. A digit is pushed directly; the arithmetic
// unit takes + and - in one step, * through its multiply state, / at one
// quotient bit per cycle and ^ at one exponent bit per cycle. The item marked
// last then moves the result into the output register.
// The output register holds a result until o_res.ready is seen; while it is
// occupied the engine waits at the next final symbol and the queue absorbs
// further input. Reset (synchronous, active low) empties the queue and the
// stack, clears the error code and selects postfix notation.
// ----------------------------------------------------------------------------
module stack_expression_evaluator import sexp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    sexp_sym_if.sink   i_sym,
    sexp_res_if.source o_res
);

    t_cmd     w_front_cmd;
    t_cmd     w_queue_cmd;
    logic     w_push;
    logic     w_pop;
    logic     w_full;
    logic     w_empty;
    t_alu_req w_alu_req;
    t_alu_rsp w_alu_rsp;

    // Decode stage: takes a transfer whenever the queue has room.
    sexp_front u_front (
        .i_sym  (i_sym),
        .i_full (w_full),
        .o_push (w_push),
        .o_cmd  (w_front_cmd)
    );

    // Queue that lets the decoder and the engine stall independently.
    sexp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_queue_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // Shared multi-cycle arithmetic for all five operators.
    sexp_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_alu_req),
        .o_rsp   (w_alu_rsp)
    );

    // Stack, error tracking and the result register.
    sexp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_empty     (w_empty),
        .i_cmd       (w_queue_cmd),
        .o_pop       (w_pop),
        .o_alu_req   (w_alu_req),
        .i_alu_rsp   (w_alu_rsp),
        .o_res       (o_res)
    );

endmodule

@@ rtl/core/sexp_front.sv @@
// ----------------------------------------------------------------------------
// Symbol front end
// Accepts symbols while the command queue has room and decodes each one
// into an operation code and a digit value.
// ----------------------------------------------------------------------------
module sexp_front import sexp_pkg::*; (
    sexp_sym_if.sink i_sym,
    input  logic     i_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    assign i_sym.ready = !i_full;
    assign o_push      = i_sym.valid && !i_full;

    always_comb begin
        o_cmd.last  = i_sym.last_symbol;
        o_cmd.digit = DIGIT_W'(i_sym.symbol - CH_0);
        unique case (i_sym.symbol) inside
            [CH_0:CH_9]: o_cmd.op = OP_DIGIT;
            CH_PLUS:     o_cmd.op = OP_ADD;
            CH_MINUS:    o_cmd.op = OP_SUB;
            CH_STAR:     o_cmd.op = OP_MUL;
            CH_SLASH:    o_cmd.op = OP_DIV;
            CH_CARET:    o_cmd.op = OP_POW;
            default:     o_cmd.op = OP_BAD;
        endcase
    end

endmodule

@@ rtl/core/sexp_fifo.sv @@
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out buffer between the front end and the stack engine.
// ----------------------------------------------------------------------------
module sexp_fifo import sexp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;

    assign o_full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("command queue written while full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("command queue read while empty");
`endif

endmodule

@@ rtl/core/sexp_alu.sv @@
// ----------------------------------------------------------------------------
// Multi-cycle arithmetic unit
// Add, subtract and multiply in one step, a restoring divider at one
// quotient bit per cycle and square-and-multiply exponentiation.
// ----------------------------------------------------------------------------
module sexp_alu import sexp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    typedef enum logic [5:0] {
        A_IDLE = 6'b000001,
        A_MUL  = 6'b000010,
        A_DIV  = 6'b000100,
        A_FIX  = 6'b001000,
        A_POW  = 6'b010000,
        A_DONE = 6'b100000
    } t_alu_state;

    t_alu_state r_state, n_state;

    logic [DATA_W-1:0] r_acc, r_base, r_exp;
    logic [DATA_W-1:0] r_rem, r_quo, r_dvs;
    logic              r_neg;
    logic [DIV_CW-1:0] r_cnt;
    logic [DATA_W-1:0] r_res;
    logic              r_err;

    logic [DATA_W-1:0] w_ab, w_bb;
    logic [DATA_W:0]   w_shift;
    logic              w_ge;
    logic [DATA_W:0]   w_diff;
    logic              w_lneg, w_rneg;

    assign w_ab    = r_acc * r_base;
    assign w_bb    = r_base * r_base;
    assign w_shift = {r_rem, r_quo[DATA_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_lneg  = i_req.lhs[DATA_W-1];
    assign w_rneg  = i_req.rhs[DATA_W-1];

    assign o_rsp.done  = (r_state == A_DONE);
    assign o_rsp.err   = r_err;
    assign o_rsp.value = r_res;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    unique case (i_req.op) inside
                        OP_MUL:                n_state = A_MUL;
                        OP_DIV:                n_state = (i_req.rhs == '0) ? A_DONE : A_DIV;
                        OP_POW:                n_state = w_rneg ? A_DONE : A_POW;
                        default:               n_state = A_DONE;
                    endcase
                end
            end
            A_MUL:   n_state = A_DONE;
            A_DIV:   n_state = (r_cnt == '0) ? A_FIX : A_DIV;
            A_FIX:   n_state = A_DONE;
            A_POW:   n_state = (r_exp == '0) ? A_DONE : A_POW;
            A_DONE:  n_state = A_IDLE;
            default: n_state = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    r_err <= 1'b0;
                    case (i_req.op)
                        OP_ADD: r_res <= i_req.lhs + i_req.rhs;
                        OP_SUB: r_res <= i_req.lhs - i_req.rhs;
                        OP_MUL: begin
                            r_acc  <= i_req.lhs;
                            r_base <= i_req.rhs;
                        end
                        OP_DIV: begin
                            r_err <= (i_req.rhs == '0);
                            r_res <= '0;
                            r_quo <= w_lneg ? (~i_req.lhs + 1'b1) : i_req.lhs;
                            r_dvs <= w_rneg ? (~i_req.rhs + 1'b1) : i_req.rhs;
                            r_neg <= w_lneg ^ w_rneg;
                            r_rem <= '0;
                            r_cnt <= DIV_CW'(DATA_W - 1);
                        end
                        OP_POW: begin
                            r_acc  <= DATA_W'(1);
                            r_base <= i_req.lhs;
                            r_exp  <= i_req.rhs;
                            // A negative exponent gives the truncated reciprocal.
                            if (i_req.lhs == '0) begin
                                r_err <= w_rneg;
                                r_res <= '0;
                            end else if (i_req.lhs == DATA_W'(1)) begin
                                r_res <= DATA_W'(1);
                            end else if (i_req.lhs == '1) begin
                                r_res <= i_req.rhs[0] ? '1 : DATA_W'(1);
                            end else begin
                                r_res <= '0;
                            end
                        end
                        default: r_res <= '0;
                    endcase
                end
            end
            A_MUL: r_res <= w_ab;
            A_DIV: begin
                r_rem <= w_ge ? w_diff[DATA_W-1:0] : w_shift[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            A_FIX: r_res <= r_neg ? (~r_quo + 1'b1) : r_quo;
            A_POW: begin
                if (r_exp == '0) begin
                    r_res <= r_acc;
                end else begin
                    if (r_exp[0]) begin
                        r_acc <= w_ab;
                    end
                    r_base <= w_bb;
                    r_exp  <= r_exp >> 1;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (r_state == A_IDLE))
        else $error("arithmetic unit started while busy");
`endif

endmodule

@@ rtl/core/sexp_back.sv @@
// ----------------------------------------------------------------------------
// Stack engine
// Pops classified symbols from the queue, keeps the operand stack and the
// sticky error code, drives the arithmetic unit and holds the result.
// ----------------------------------------------------------------------------
module sexp_back import sexp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_empty,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output t_alu_req   o_alu_req,
    input  t_alu_rsp   i_alu_rsp,
    sexp_res_if.source o_res
);

    typedef enum logic [3:0] {
        B_IDLE   = 4'b0001,
        B_OPER   = 4'b0010,
        B_WAIT   = 4'b0100,
        B_RESULT = 4'b1000
    } t_back_state;

    t_back_state r_state, n_state;

    logic [DATA_W-1:0]   r_stack [STACK_DEPTH];
    logic [SP_W-1:0]     r_sp, n_sp;
    logic [STATUS_W-1:0] r_err, n_err;
    logic [DATA_W-1:0]   r_top, n_top;
    logic [DATA_W-1:0]   r_next;
    t_cmd                r_cmd;
    logic                r_mode;

    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_value;
    logic [STATUS_W-1:0] r_out_status;

    logic                w_we;
    logic [STK_AW-1:0]   w_waddr;
    logic [DATA_W-1:0]   w_wdata;
    logic [STK_AW-1:0]   w_raddr;
    logic                w_load;
    logic [STATUS_W-1:0] w_status;

    assign o_pop   = (r_state == B_IDLE) && !i_empty;
    assign w_raddr = STK_AW'(r_sp - SP_W'(2));
    assign w_load  = (r_state == B_RESULT) && (!r_out_valid || o_res.ready);

    // Final status: a pending error wins, then an empty stack reads as underflow.
    assign w_status = (r_err != ST_OK) ? r_err :
                      (r_sp == '0) ? ST_UNDERFLOW : ST_OK;

    assign o_alu_req.start = (r_state == B_OPER);
    assign o_alu_req.op    = r_cmd.op;
    assign o_alu_req.lhs   = r_mode ? r_top : r_next;
    assign o_alu_req.rhs   = r_mode ? r_next : r_top;

    assign o_res.valid  = r_out_valid;
    assign o_res.value  = $signed(r_out_value);
    assign o_res.status = r_out_status;

    always_comb begin
        n_state = r_state;
        n_sp    = r_sp;
        n_err   = r_err;
        n_top   = r_top;
        w_we    = 1'b0;
        w_waddr = r_sp[STK_AW-1:0];
        w_wdata = DATA_W'(i_cmd.digit);
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    n_state = i_cmd.last ? B_RESULT : B_IDLE;
                    if (r_err == ST_OK) begin
                        unique case (i_cmd.op) inside
                            OP_DIGIT: begin
                                if (r_sp == SP_W'(STACK_DEPTH)) begin
                                    n_err = ST_OVERFLOW;
                                end else begin
                                    w_we  = 1'b1;
                                    n_top = DATA_W'(i_cmd.digit);
                                    n_sp  = r_sp + 1'b1;
                                end
                            end
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW: begin
                                if (r_sp < SP_W'(2)) begin
                                    n_err = ST_UNDERFLOW;
                                end else begin
                                    n_state = B_OPER;
                                end
                            end
                            default: n_err = ST_BADCHAR;
                        endcase
                    end
                end
            end
            B_OPER: n_state = B_WAIT;
            B_WAIT: begin
                if (i_alu_rsp.done) begin
                    n_state = r_cmd.last ? B_RESULT : B_IDLE;
                    if (i_alu_rsp.err) begin
                        n_err = ST_DIVZERO;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = w_raddr;
                        w_wdata = i_alu_rsp.value;
                        n_top   = i_alu_rsp.value;
                        n_sp    = r_sp - 1'b1;
                    end
                end
            end
            B_RESULT: begin
                if (w_load) begin
                    n_state = B_IDLE;
                    n_sp    = '0;
                    n_err   = ST_OK;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_sp        <= '0;
            r_err       <= ST_OK;
            r_mode      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (w_load) begin
            r_out_status <= w_status;
            r_out_value  <= (w_status == ST_OK) ? r_top : '0;
        end
    end

    // Operand stack: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_stack[w_waddr] <= w_wdata;
        end
        r_next <= r_stack[w_raddr];
    end

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");
    a_err_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ST_OK && r_state != B_RESULT) |=> $stable(r_sp))
        else $error("stack changed while an error is pending");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> (r_out_value == '0))
        else $error("nonzero value returned with an error status");
`endif

endmodule

@@ dv/stack_expression_evaluator_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack expression evaluator result checker
// Watches the symbol and result channels and the notation write port, keeps
// its own copy of the operand stack and error state, predicts the value and
// status of every finished expression and compares them in order.
// ----------------------------------------------------------------------------
module stack_expression_evaluator_checker import sexp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    sexp_sym_if  i_sym,
    sexp_res_if  i_res,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic signed [DATA_W-1:0]   value;
        logic        [STATUS_W-1:0] status;
    } t_result;

    logic [DATA_W-1:0]   operand_stk [STACK_DEPTH];
    int                  depth_live;
    logic [STATUS_W-1:0] err_code;
    logic                notation;
    t_result             results_due [$];
    t_result             got_res;
    t_result             want_res;
    int                  fail_tally;

    // Signed division that truncates toward zero; -2^31 / -1 wraps.
    function automatic logic [DATA_W-1:0] quotient_trunc(input logic [DATA_W-1:0] num,
                                                         input logic [DATA_W-1:0] den);
        logic [DATA_W-1:0] num_mag;
        logic [DATA_W-1:0] den_mag;
        logic [DATA_W-1:0] quo;
        num_mag = num[DATA_W-1] ? -num : num;
        den_mag = den[DATA_W-1] ? -den : den;
        quo     = num_mag / den_mag;
        return (num[DATA_W-1] ^ den[DATA_W-1]) ? -quo : quo;
    endfunction

    // Power modulo 2^32. Returns 0 when the result is undefined, which is
    // a zero base raised to a negative exponent.
    function automatic logic power_wrap(input  logic [DATA_W-1:0] base_w,
                                        input  logic [DATA_W-1:0] expo,
                                        output logic [DATA_W-1:0] res);
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] sq;
        logic [DATA_W-1:0] rest;
        res = '0;
        if (expo[DATA_W-1]) begin
            if (base_w == '0) begin
                return 1'b0;
            end
            if (base_w == DATA_W'(1)) begin
                res = DATA_W'(1);
            end else if (base_w == {DATA_W{1'b1}}) begin
                res = expo[0] ? {DATA_W{1'b1}} : DATA_W'(1);
            end
            return 1'b1;
        end
        acc  = DATA_W'(1);
        sq   = base_w;
        rest = expo;
        while (rest != '0) begin
            if (rest[0]) begin
                acc = acc * sq;
            end
            sq   = sq * sq;
            rest = rest >> 1;
        end
        res = acc;
        return 1'b1;
    endfunction

    // Applies one symbol to the stack while no error is latched.
    task automatic apply_symbol(input logic [SYM_W-1:0] ch);
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] outcome;
        logic              defined;
        if (ch >= CH_0 && ch <= CH_9) begin
            if (depth_live >= STACK_DEPTH) begin
                err_code = ST_OVERFLOW;
            end else begin
                operand_stk[depth_live] = DATA_W'(ch - CH_0);
                depth_live++;
            end
            return;
        end
        if (!(ch inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET})) begin
            err_code = ST_BADCHAR;
            return;
        end
        if (depth_live < 2) begin
            err_code = ST_UNDERFLOW;
            return;
        end
        // Postfix takes the deeper entry as the left operand; reverse-fed
        // prefix takes the top.
        lhs     = notation ? operand_stk[depth_live-1] : operand_stk[depth_live-2];
        rhs     = notation ? operand_stk[depth_live-2] : operand_stk[depth_live-1];
        outcome = '0;
        defined = 1'b1;
        case (ch)
            CH_PLUS: begin
                outcome = lhs + rhs;
            end
            CH_MINUS: begin
                outcome = lhs - rhs;
            end
            CH_STAR: begin
                outcome = lhs * rhs;
            end
            CH_SLASH: begin
                if (rhs == '0) begin
                    defined = 1'b0;
                end else begin
                    outcome = quotient_trunc(lhs, rhs);
                end
            end
            default: begin
                defined = power_wrap(lhs, rhs, outcome);
            end
        endcase
        if (!defined) begin
            err_code = ST_DIVZERO;
            return;
        end
        depth_live--;
        operand_stk[depth_live-1] = outcome;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            depth_live = 0;
            err_code   = ST_OK;
            notation   = 1'b0;
            fail_tally = 0;
            results_due.delete();
        end else begin
            if (i_cfg_we) begin
                notation = i_cfg_wdata;
            end
            if (i_sym.valid && i_sym.ready) begin
                if (err_code == ST_OK) begin
                    apply_symbol(i_sym.symbol);
                end
                if (i_sym.last_symbol) begin
                    want_res.status = err_code;
                    want_res.value  = '0;
                    if (err_code == ST_OK) begin
                        if (depth_live == 0) begin
                            want_res.status = ST_UNDERFLOW;
                        end else begin
                            want_res.value = operand_stk[depth_live-1];
                        end
                    end
                    results_due.push_back(want_res);
                    depth_live = 0;
                    err_code   = ST_OK;
                end
            end
            if (i_res.valid && i_res.ready) begin
                got_res.value  = i_res.value;
                got_res.status = i_res.status;
                if (results_due.size() == 0) begin
                    if (fail_tally < 10) begin
                        $display("%t: result with none pending: value %0d status %0d",
                                 $realtime, got_res.value, got_res.status);
                    end
                    fail_tally++;
                end else begin
                    want_res = results_due.pop_front();
                    if (got_res.value !== want_res.value ||
                        got_res.status !== want_res.status) begin
                        if (fail_tally < 10) begin
                            $display("%t: expected value %0d status %0d, got %0d status %0d",
                                     $realtime, want_res.value, want_res.status,
                                     got_res.value, got_res.status);
                        end
                        fail_tally++;
                    end
                end
            end
        end
        o_fail_count <= fail_tally;
        o_pending    <= results_due.size();
    end

endmodule

@@ dv/stack_expression_evaluator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack expression evaluator testbench
// Drives symbol streams in both notations, with a directed opening and then
// random expressions, broken sequences and noise, under random sender gaps
// and receiver stalls. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module stack_expression_evaluator_tb;
    import sexp_pkg::*;

    // A watchdog ends the run after this many cycles without any transfer.
    // The slowest correct gap is a divide or power in the engine plus a
    // receiver stall, or the settle time before a notation write, so this
    // leaves a wide margin.
    localparam int STALL_LIMIT   = 4000;
    // Cycles allowed after the last result before the block is taken as idle.
    localparam int SETTLE_CYCLES = 64;
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_ITEMS   = 305;

    localparam logic [SYM_W-1:0] OPERATOR_CHARS [5] =
        '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};

    // 2^31 built from digits: 2 ^ (4 * 8 - 1). It reads as -2^31 when signed.
    localparam string MIN_INT_EXPR = "248*1-^";

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_BLOCKED,
        RX_HEAVY
    } t_rx_style;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic      cfg_wdata;
    int        eval_fails;
    int        eval_pending;
    int        items_sent;
    int        burst_left;
    logic      mode_now;
    int        quiet_cycles;
    logic [7:0] rx_cycle;
    t_rx_style rx_style;

    sexp_sym_if sym_ch ();
    sexp_res_if res_ch ();

    stack_expression_evaluator uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_sym       (sym_ch),
        .o_res       (res_ch)
    );

    // The checker sits beside the block and only watches its ports.
    stack_expression_evaluator_checker eval_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_sym        (sym_ch),
        .i_res        (res_ch),
        .o_fail_count (eval_fails),
        .o_pending    (eval_pending)
    );

    // 8 ns clock period.
    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // The result receiver redraws its stall style as its cycle counter wraps:
    // always ready, lightly stalled, blocked while counter bits 4:3 are both
    // set, or mostly stalled, which moves stalls across all the engine's work.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            rx_cycle     <= '0;
            rx_style     <= RX_OPEN;
        end else begin
            rx_cycle <= rx_cycle + 8'd1;
            if (rx_cycle == 8'hFF) begin
                rx_style <= t_rx_style'($urandom_range(0, 3));
            end
            case (rx_style)
                RX_OPEN: begin
                    res_ch.ready <= 1'b1;
                end
                RX_LIGHT: begin
                    res_ch.ready <= ($urandom_range(0, 3) != 0);
                end
                RX_BLOCKED: begin
                    res_ch.ready <= (rx_cycle[4:3] != 2'b11);
                end
                default: begin
                    res_ch.ready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge clk) begin
        if (!rst_n || (sym_ch.valid && sym_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("** stack_expression_evaluator: FAILED **");
                $finish;
            end
        end
    end

    // Sends one symbol and returns at the clock edge where it is transferred.
    // The sender works in bursts; between bursts it may drop valid for a
    // random gap, or carry straight on so that gapless stretches occur too.
    // Valid is only lowered for a nonzero gap, so it never gets two
    // assignments in the same step.
    task automatic send_symbol(input logic [SYM_W-1:0] ch, input logic fin);
        int gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                sym_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        sym_ch.valid       <= 1'b1;
        sym_ch.symbol      <= ch;
        sym_ch.last_symbol <= fin;
        do begin
            @(posedge clk);
        end while (!sym_ch.ready);
        burst_left--;
        items_sent++;
    endtask

    // Expressions are written as postfix text. In prefix mode the same
    // expression is fed right to left, which for an operator node means the
    // right subtree first, then the left subtree, then the operator. Text in
    // which an operator lacks an operand is sent unchanged.
    function automatic string to_feed_order(input string pf);
        string parts [$];
        string lhs_s;
        string rhs_s;
        string joined;
        int    i;
        if (!mode_now) begin
            return pf;
        end
        for (i = 0; i < pf.len(); i++) begin
            if (pf[i] inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET}) begin
                if (parts.size() < 2) begin
                    return pf;
                end
                rhs_s = parts.pop_back();
                lhs_s = parts.pop_back();
                parts.push_back({rhs_s, lhs_s, pf.substr(i, i)});
            end else begin
                parts.push_back(pf.substr(i, i));
            end
        end
        joined = "";
        foreach (parts[k]) begin
            joined = {joined, parts[k]};
        end
        return joined;
    endfunction

    // Sends a whole expression; its final character is marked last.
    task automatic feed_expr(input string pf);
        string seq;
        int    i;
        seq = to_feed_order(pf);
        for (i = 0; i < seq.len(); i++) begin
            send_symbol(seq[i], i == seq.len() - 1);
        end
    endtask

    // Random well-formed postfix tree, at most levels operators deep, so that
    // it never needs more than levels + 1 stack entries.
    function automatic string rand_tree(input int levels);
        if (levels == 0 || $urandom_range(0, 2) == 0) begin
            return $sformatf("%c", CH_0 + $urandom_range(0, 9));
        end
        return {rand_tree(levels - 1), rand_tree(levels - 1),
                $sformatf("%c", OPERATOR_CHARS[$urandom_range(0, 4)])};
    endfunction

    // Drops valid, waits until every predicted result has been transferred,
    // then lets the given number of extra cycles pass.
    task automatic wait_drained(input int settle);
        sym_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (eval_pending != 0) begin
            @(posedge clk);
        end
        repeat (settle) @(posedge clk);
    endtask

    // Notation writes happen only with the block idle.
    task automatic set_notation(input logic mode);
        wait_drained(SETTLE_CYCLES);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        mode_now = mode;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One random expression. Most are well formed with random content; the
    // rest are stack overflows, negative powers, the most negative value,
    // corrupted trees, surplus or missing operands, and raw noise bytes.
    task automatic send_random_expression();
        string pf;
        int    pick;
        int    n;
        int    i;
        pick = $urandom_range(0, 99);
        if (pick < 58) begin
            feed_expr(rand_tree($urandom_range(0, 5)));
        end else if (pick < 64) begin
            // Surplus operand, or an operator too many.
            if ($urandom_range(0, 1) == 0) begin
                pf = {rand_tree($urandom_range(0, 3)), rand_tree($urandom_range(0, 3))};
            end else begin
                pf = {rand_tree($urandom_range(0, 3)),
                      $sformatf("%c", OPERATOR_CHARS[$urandom_range(0, 4)])};
            end
            feed_expr(pf);
        end else if (pick < 71) begin
            // A run of digits around the stack depth, so that some overflow.
            pf = "";
            n  = $urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 2);
            for (i = 0; i < n; i++) begin
                pf = {pf, $sformatf("%c", CH_0 + $urandom_range(0, 9))};
            end
            if ($urandom_range(0, 1) == 0) begin
                pf = {pf, $sformatf("%c", OPERATOR_CHARS[$urandom_range(0, 4)])};
            end
            feed_expr(pf);
        end else if (pick < 77) begin
            // Power with a negative exponent on the interesting bases,
            // zero among them.
            case ($urandom_range(0, 5))
                0: pf = "0";
                1: pf = "1";
                2: pf = "01-";
                3: pf = "2";
                4: pf = "03-";
                default: pf = rand_tree(2);
            endcase
            pf = {pf, "0", $sformatf("%c", CH_0 + $urandom_range(1, 9)), "-^"};
            feed_expr(pf);
        end else if (pick < 82) begin
            // The most negative value, divided by minus one among others.
            case ($urandom_range(0, 3))
                0: pf = {MIN_INT_EXPR, "01-/"};
                1: pf = {MIN_INT_EXPR, "1-"};
                2: pf = {MIN_INT_EXPR, "01-*"};
                default: pf = {MIN_INT_EXPR, rand_tree(2), "/"};
            endcase
            feed_expr(pf);
        end else if (pick < 91) begin
            // A tree with one character replaced by an arbitrary byte.
            pf = to_feed_order(rand_tree($urandom_range(1, 4)));
            pf.putc($urandom_range(0, pf.len() - 1), 8'($urandom_range(1, 255)));
            for (i = 0; i < pf.len(); i++) begin
                send_symbol(pf[i], i == pf.len() - 1);
            end
        end else begin
            // Raw noise bytes over the whole symbol range.
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) begin
                send_symbol(8'($urandom_range(0, 255)), i == n - 1);
            end
        end
    endtask

    initial begin
        int phase;
        int items_base;

        // The sender's outputs are known from time zero; the receiver's
        // ready comes out of its own block during reset.
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= 1'b0;
        sym_ch.valid       <= 1'b0;
        sym_ch.symbol      <= '0;
        sym_ch.last_symbol <= 1'b0;
        items_sent = 0;
        burst_left = 0;
        mode_now   = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening in postfix notation: digit extremes, every
        // operator, divide by zero, an operator on an empty stack, a bad
        // character that stays sticky while later symbols are ignored,
        // surplus operands, and the top symbol code.
        set_notation(1'b0);
        feed_expr("0");
        feed_expr("37-9*");
        feed_expr("59+2^7/");
        feed_expr("40/");
        feed_expr("+");
        send_symbol(CH_0 + 8'd1, 1'b0);
        send_symbol(8'h00, 1'b0);
        send_symbol(CH_0 + 8'd2, 1'b1);
        feed_expr("12");
        send_symbol(8'hFF, 1'b1);

        // The same operand order checks in prefix notation.
        set_notation(1'b1);
        feed_expr("37-");
        feed_expr("23^");
        feed_expr("40/");

        // Random phases alternate the notation, each one starting idle.
        items_base = items_sent;
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            set_notation(phase[0]);
            while (items_sent < items_base + (phase + 1) * PHASE_ITEMS) begin
                send_random_expression();
                // Now and then the sender holds back until all results are in.
                if ($urandom_range(0, 29) == 0) begin
                    wait_drained(0);
                end
            end
        end

        wait_drained(SETTLE_CYCLES);
        if (eval_fails == 0) begin
            $display("** stack_expression_evaluator: PASSED **");
        end else begin
            $display("** stack_expression_evaluator: FAILED **");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/sexp_pkg.sv
rtl/core/sexp_if.sv
rtl/core/sexp_front.sv
rtl/core/sexp_fifo.sv
rtl/core/sexp_alu.sv
rtl/core/sexp_back.sv
rtl/core/stack_expression_evaluator.sv
dv/stack_expression_evaluator_checker.sv
dv/stack_expression_evaluator_tb.sv
